@@ rtl/sbb_pkg.sv @@
// ----------------------------------------------------------------------------
// sbb_pkg: shared types and constants for the spectrum band bar block
// Fixed-point thresholds, gains, register indexes, back-end states and the
// elaboration-time ln() weight function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbb_pkg;

  // Field widths
  localparam int BIN_W   = 20;
  localparam int LEVEL_W = 16;
  localparam int IDX_W   = 5;
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 24;
  localparam int CFG_DATA_W = 16;
  localparam int BPB_CFG_W  = 7;

  // ln(b+2) in Q.16 stays below 2^19 for up to 256 bands
  localparam int WEIGHT_W = 19;

  // Gain value and gain factor widths
  localparam int GAIN_W = 21;
  localparam int GAIN_IN_W = 15;

  localparam int FIFO_DEPTH = 4;

  // Register indexes
  localparam logic REG_DECAY_STEP    = 1'b0;
  localparam logic REG_BINS_PER_BAND = 1'b1;

  localparam logic [LEVEL_W-1:0]   DECAY_STEP_RST    = 16'd3277;
  localparam logic [BPB_CFG_W-1:0] BINS_PER_BAND_RST = 7'd8;

  // Q.16 thresholds and levels
  localparam logic [31:0] TH_0005  = 32'd328;
  localparam logic [31:0] TH_0009  = 32'd590;
  localparam logic [31:0] TH_001   = 32'd655;
  localparam logic [31:0] TH_01    = 32'd6554;
  localparam logic [31:0] TH_05    = 32'd32768;
  localparam logic [31:0] TH_ONE   = 32'd65536;
  localparam logic [31:0] LEVEL_MAX = 32'd65535;
  localparam logic [LEVEL_W-1:0] LEVEL_09 = 16'd58982;

  // Q.16 gains
  localparam logic [GAIN_W-1:0] GAIN_9PI = 21'd1852995;
  localparam logic [GAIN_W-1:0] GAIN_3PI = 21'd617665;
  localparam logic [GAIN_W-1:0] GAIN_PI  = 21'd205887;

  localparam logic [63:0] LN2_Q32 = 64'd2977044472;

  typedef enum logic [2:0] {
    B_IDLE,
    B_WEIGHT,
    B_SCALE,
    B_GAIN,
    B_UPDATE
  } back_state_t;

  // ln(n) in Q.16 via log2 by repeated squaring; evaluated at elaboration only
  function automatic logic [63:0] ln_q16(input int unsigned n);
    int unsigned k;
    int          i;
    int          j;
    logic [63:0] m;
    logic [63:0] frac;
    logic [63:0] log2v;
    k = 0;
    for (j = 0; j < 31; j++) begin
      if ((n >> (j + 1)) != 0) k = j + 1;
    end
    m = 64'(n) << (30 - k);
    frac = 64'd0;
    for (i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    log2v = (64'(k) << 16) | frac;
    return (log2v * LN2_Q32 + (64'd1 << 31)) >> 32;
  endfunction

endpackage

`default_nettype wire

@@ rtl/sbb_fifo.sv @@
// ----------------------------------------------------------------------------
// sbb_fifo: band queue between front end and back end
// Small register FIFO holding completed band sums with their band numbers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbb_fifo #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  localparam int PTR_W = $clog2(sbb_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(sbb_pkg::FIFO_DEPTH + 1);

  logic [WIDTH-1:0] entries [sbb_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(sbb_pkg::FIFO_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

@@ rtl/sbb_front.sv @@
// ----------------------------------------------------------------------------
// sbb_front: bin accumulator
// Sums bins into bands, tracks the band number and queues each finished band.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbb_front #(
  parameter int BANDS             = 32,
  parameter int MAX_BINS_PER_BAND = 64,
  parameter int SUM_W             = 26,
  parameter int BAND_W            = 5
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [sbb_pkg::BIN_W-1:0]          bin_value,
  input  wire logic                               frame_start,
  input  wire logic [sbb_pkg::BPB_CFG_W-1:0]      bins_per_band,
  output logic                                    push,
  output logic [BAND_W+SUM_W-1:0]                 push_data,
  input  wire logic                               queue_full
);

  localparam int CNT_W = (MAX_BINS_PER_BAND > 1) ? $clog2(MAX_BINS_PER_BAND) : 1;
  localparam int BPB_W = (MAX_BINS_PER_BAND > 1) ? $clog2(MAX_BINS_PER_BAND + 1) : 1;

  logic [SUM_W-1:0]  band_sum;
  logic [CNT_W-1:0]  bin_count;
  logic [BAND_W-1:0] band_counter;

  logic [SUM_W-1:0]  base_sum;
  logic [CNT_W-1:0]  base_cnt;
  logic [BAND_W-1:0] base_band;
  logic [SUM_W-1:0]  sum_next;
  logic [BPB_W-1:0]  cnt_inc;
  logic [31:0]       bpb_wide;
  logic [BPB_W-1:0]  bpb_eff;
  logic              close_band;
  logic              accept;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  // Zero counts as one, and the setting saturates at the largest band size
  always_comb begin
    if (bins_per_band == '0) bpb_wide = 32'd1;
    else if (32'(bins_per_band) > 32'(MAX_BINS_PER_BAND)) bpb_wide = 32'(MAX_BINS_PER_BAND);
    else bpb_wide = 32'(bins_per_band);
    bpb_eff = BPB_W'(bpb_wide);
  end

  always_comb begin
    base_sum   = frame_start ? '0 : band_sum;
    base_cnt   = frame_start ? '0 : bin_count;
    base_band  = frame_start ? '0 : band_counter;
    sum_next   = base_sum + SUM_W'(bin_value);
    cnt_inc    = BPB_W'(base_cnt) + BPB_W'(1);
    close_band = (cnt_inc >= bpb_eff);
  end

  assign push      = accept && close_band;
  assign push_data = {base_band, sum_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      band_sum     <= '0;
      bin_count    <= '0;
      band_counter <= '0;
    end else if (accept) begin
      if (close_band) begin
        band_sum  <= '0;
        bin_count <= '0;
        // wrap after the last band: a new frame begins implicitly
        if (base_band == BAND_W'(BANDS - 1)) band_counter <= '0;
        else band_counter <= base_band + BAND_W'(1);
      end else begin
        band_sum     <= sum_next;
        bin_count    <= CNT_W'(cnt_inc);
        band_counter <= base_band;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/sbb_back.sv @@
// ----------------------------------------------------------------------------
// sbb_back: band shaping and level hold
// Weights a band sum by ln(band+2), applies the piecewise gain and limit,
// updates the held level with decay and drives the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbb_back #(
  parameter int BANDS  = 32,
  parameter int SUM_W  = 26,
  parameter int BAND_W = 5
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          queue_empty,
  input  wire logic [BAND_W+SUM_W-1:0]       queue_data,
  output logic                               pop,
  input  wire logic [sbb_pkg::LEVEL_W-1:0]   decay_step,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [sbb_pkg::IDX_W-1:0]          band_index,
  output logic [sbb_pkg::LEVEL_W-1:0]        bar_level,
  output logic                               last_band
);

  localparam int LW  = sbb_pkg::LEVEL_W;
  localparam int P1_W = SUM_W + sbb_pkg::WEIGHT_W;
  localparam int V_W  = P1_W + 1 - 16;
  localparam int P2_W = sbb_pkg::GAIN_IN_W + sbb_pkg::GAIN_W;
  localparam int G_W  = P2_W + 1 - 16;

  localparam logic [V_W-1:0] V_TH_0005 = V_W'(sbb_pkg::TH_0005);
  localparam logic [V_W-1:0] V_TH_0009 = V_W'(sbb_pkg::TH_0009);
  localparam logic [V_W-1:0] V_TH_001  = V_W'(sbb_pkg::TH_001);
  localparam logic [V_W-1:0] V_TH_01   = V_W'(sbb_pkg::TH_01);
  localparam logic [V_W-1:0] V_TH_05   = V_W'(sbb_pkg::TH_05);
  localparam logic [V_W-1:0] V_ONE     = V_W'(sbb_pkg::TH_ONE);
  localparam logic [V_W-1:0] V_MAX     = V_W'(sbb_pkg::LEVEL_MAX);

  sbb_pkg::back_state_t state;
  sbb_pkg::back_state_t state_next;

  logic [sbb_pkg::WEIGHT_W-1:0] weight_rom [BANDS];

  logic [LW-1:0]     held_mem [BANDS];
  logic [BANDS-1:0]  held_vld;
  logic [LW-1:0]     held_rd;
  logic              held_rd_vld;

  logic [BAND_W-1:0]            band_q;
  logic [SUM_W-1:0]             sum_q;
  logic [P1_W-1:0]              p1;
  logic [V_W-1:0]               v;
  logic [sbb_pkg::GAIN_W-1:0]   gain_k;
  logic                         gain_on;
  logic [P2_W-1:0]              p2;

  logic [P1_W:0]                p1_round;
  logic [V_W-1:0]               v_new;
  logic [sbb_pkg::GAIN_W-1:0]   gain_sel;
  logic                         gain_sel_on;
  logic [P2_W:0]                p2_round;
  logic [V_W-1:0]               shaped;
  logic [LW-1:0]                level;
  logic [LW-1:0]                old_level;
  logic [LW:0]                  level_plus;
  logic [LW-1:0]                held_new;
  logic                         out_free;
  logic                         finish;

  // ln(band+2) weights, fixed at elaboration
  for (genvar b = 0; b < BANDS; b++) begin : g_weight
    assign weight_rom[b] = sbb_pkg::WEIGHT_W'(sbb_pkg::ln_q16(b + 2));
  end

  assign out_free = !out_valid || out_ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      sbb_pkg::B_IDLE:   if (!queue_empty) state_next = sbb_pkg::B_WEIGHT;
      sbb_pkg::B_WEIGHT: state_next = sbb_pkg::B_SCALE;
      sbb_pkg::B_SCALE:  state_next = sbb_pkg::B_GAIN;
      sbb_pkg::B_GAIN:   state_next = sbb_pkg::B_UPDATE;
      sbb_pkg::B_UPDATE: begin
        if (out_free) state_next = queue_empty ? sbb_pkg::B_IDLE : sbb_pkg::B_WEIGHT;
      end
      default:           state_next = sbb_pkg::B_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    pop    = 1'b0;
    finish = 1'b0;
    case (state)
      sbb_pkg::B_IDLE:   pop = !queue_empty;
      sbb_pkg::B_UPDATE: begin
        finish = out_free;
        pop    = out_free && !queue_empty;
      end
      default: begin
        pop    = 1'b0;
        finish = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= sbb_pkg::B_IDLE;
    else state <= state_next;
  end

  // Rounding, gain selection and limit
  always_comb begin
    p1_round = {1'b0, p1} + (P1_W + 1)'(32'h8000);
    v_new    = V_W'(p1_round >> 16);

    gain_sel    = '0;
    gain_sel_on = 1'b0;
    if (v_new > V_TH_0005 && v_new < V_TH_0009) begin
      gain_sel    = sbb_pkg::GAIN_9PI;
      gain_sel_on = 1'b1;
    end else if (v_new > V_TH_001 && v_new < V_TH_01) begin
      gain_sel    = sbb_pkg::GAIN_3PI;
      gain_sel_on = 1'b1;
    end else if (v_new > V_TH_01 && v_new < V_TH_05) begin
      gain_sel    = sbb_pkg::GAIN_PI;
      gain_sel_on = 1'b1;
    end

    p2_round = {1'b0, p2} + (P2_W + 1)'(32'h8000);
    shaped   = gain_on ? V_W'(G_W'(p2_round >> 16)) : v;

    if (shaped > V_ONE) level = sbb_pkg::LEVEL_09;
    else if (shaped > V_MAX) level = LW'(sbb_pkg::LEVEL_MAX);
    else level = LW'(shaped);

    old_level  = held_rd_vld ? held_rd : '0;
    level_plus = {1'b0, level} + {1'b0, decay_step};
    if (old_level <= decay_step || level_plus >= {1'b0, old_level}) held_new = level;
    else held_new = old_level - decay_step;
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      band_q <= queue_data[BAND_W+SUM_W-1:SUM_W];
      sum_q  <= queue_data[SUM_W-1:0];
    end
    if (state == sbb_pkg::B_WEIGHT) begin
      p1      <= P1_W'(sum_q) * P1_W'(weight_rom[band_q]);
      held_rd <= held_mem[band_q];
    end
    if (state == sbb_pkg::B_SCALE) begin
      v       <= v_new;
      gain_k  <= gain_sel;
      gain_on <= gain_sel_on;
    end
    if (state == sbb_pkg::B_GAIN) begin
      // gain only applies below one half, so the low bits carry the value
      p2 <= P2_W'(v[sbb_pkg::GAIN_IN_W-1:0]) * P2_W'(gain_k);
    end
    if (finish) held_mem[band_q] <= held_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_vld    <= '0;
      held_rd_vld <= 1'b0;
    end else begin
      if (state == sbb_pkg::B_WEIGHT) held_rd_vld <= held_vld[band_q];
      if (finish) held_vld[band_q] <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      band_index <= sbb_pkg::IDX_W'(band_q);
      bar_level  <= held_new;
      last_band  <= (band_q == BAND_W'(BANDS - 1));
    end
  end

endmodule

`default_nettype wire

@@ rtl/spectrum_band_bars_with_decay_core.sv @@
// ----------------------------------------------------------------------------
// spectrum_band_bars_with_decay_core: spectrum analyzer band bars with falloff
// Sums FFT bins into bands and reports one decaying bar level per band.
// ----------------------------------------------------------------------------
// The front end accepts one bin per cycle while the queue is not full and
// sums bins_per_band bins into a band; frame_start (in s_tuser) restarts the
// band count. Each finished band goes through a four-entry queue to the back
// end, which takes one band at a time through weight multiply, rounding and
// gain select, gain multiply and level update, and holds the band level in a
// BANDS-deep memory whose valid bits reset clears, so no clearing pass is
// needed. Bins stream at one per cycle whenever bins_per_band is 4 or more and
// m_tready does not stall the output; with smaller bands the input stalls once
// the queue fills. Configuration writes are taken every cycle.
`timescale 1ns / 1ps
`default_nettype none

module spectrum_band_bars_with_decay_core #(
  parameter int BANDS             = 32,
  parameter int MAX_BINS_PER_BAND = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [sbb_pkg::S_DATA_W-1:0]     s_tdata,   // [19:0] bin_value
  input  wire logic                             s_tuser,   // [0] frame_start
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [sbb_pkg::M_DATA_W-1:0]          m_tdata,   // [4:0] band_index, [20:5] bar_level
  output logic                                  m_tlast,   // last_band
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic                             cfg_index,
  input  wire logic [sbb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int SUM_W  = sbb_pkg::BIN_W +
                          ((MAX_BINS_PER_BAND > 1) ? $clog2(MAX_BINS_PER_BAND) : 0);
  localparam int BAND_W = $clog2(BANDS);
  localparam int Q_W    = BAND_W + SUM_W;

  logic [sbb_pkg::LEVEL_W-1:0]   decay_step;
  logic [sbb_pkg::BPB_CFG_W-1:0] bins_per_band;

  logic                          q_push;
  logic [Q_W-1:0]                q_push_data;
  logic                          q_full;
  logic                          q_pop;
  logic [Q_W-1:0]                q_pop_data;
  logic                          q_empty;

  logic [sbb_pkg::IDX_W-1:0]     band_index;
  logic [sbb_pkg::LEVEL_W-1:0]   bar_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_step    <= sbb_pkg::DECAY_STEP_RST;
      bins_per_band <= sbb_pkg::BINS_PER_BAND_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sbb_pkg::REG_DECAY_STEP:    decay_step <= cfg_data;
        sbb_pkg::REG_BINS_PER_BAND: bins_per_band <= cfg_data[sbb_pkg::BPB_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  sbb_front #(
    .BANDS             (BANDS),
    .MAX_BINS_PER_BAND (MAX_BINS_PER_BAND),
    .SUM_W             (SUM_W),
    .BAND_W            (BAND_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .bin_value     (s_tdata[sbb_pkg::BIN_W-1:0]),
    .frame_start   (s_tuser),
    .bins_per_band (bins_per_band),
    .push          (q_push),
    .push_data     (q_push_data),
    .queue_full    (q_full)
  );

  sbb_fifo #(
    .WIDTH (Q_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  sbb_back #(
    .BANDS  (BANDS),
    .SUM_W  (SUM_W),
    .BAND_W (BAND_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (q_empty),
    .queue_data  (q_pop_data),
    .pop         (q_pop),
    .decay_step  (decay_step),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .band_index  (band_index),
    .bar_level   (bar_level),
    .last_band   (m_tlast)
  );

  assign m_tdata = {3'b000, bar_level, band_index};

endmodule

`default_nettype wire

@@ rtl/sbb_checker.sv @@
// ----------------------------------------------------------------------------
// sbb_checker: port-level checks for the band bar core
// Watches the top-level ports over time; bound to the core below.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbb_checker #(
  parameter int BANDS = 32
) (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [sbb_pkg::M_DATA_W-1:0]   m_tdata,
  input wire logic                           m_tlast
);

  localparam logic [sbb_pkg::IDX_W-1:0] LAST_IDX = sbb_pkg::IDX_W'(BANDS - 1);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // the final band flag only on the last band number
  a_last_band: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[4:0] == LAST_IDX)
    else $error("last band flag on wrong band");

  // padding above the bar level stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[23:21] == 3'b000)
    else $error("nonzero padding in result");

endmodule

bind spectrum_band_bars_with_decay_core sbb_checker #(.BANDS(BANDS)) u_sbb_checker (.*);

`default_nettype wire
